// ----- sv/glpl_pkg.sv -----
// ----------------------------------------------------------------------------
// glpl_pkg: shared types and constants of the gas sensor ppm linearizer
// Widths, status codes, the reading record and the exp2 fraction table.
// ----------------------------------------------------------------------------
package glpl_pkg;

	localparam int AdcBits       = 12;
	localparam int ExpTableDepth = 1024;
	localparam int ExpIdxW       = $clog2(ExpTableDepth);
	localparam int SumW          = AdcBits + 8;
	localparam int CntW          = 9;
	localparam int CvW           = 9;
	localparam int LogW          = 24;
	localparam int FifoDepth     = 2;
	localparam int FifoPtrW      = $clog2(FifoDepth);

	localparam logic [CvW-1:0] CvFull = 9'd330;

	localparam logic [1:0] StOk     = 2'd0;
	localparam logic [1:0] StNoCal  = 2'd1;
	localparam logic [1:0] StZero   = 2'd2;
	localparam logic [1:0] StSat    = 2'd3;

	localparam logic [1:0] RegSamples = 2'd0;
	localparam logic [1:0] RegCalPpm  = 2'd1;
	localparam logic [1:0] RegExp     = 2'd2;

	typedef struct packed {
		logic [SumW-1:0] sum;
		logic [CntW-1:0] count;
		logic            calib;
	} reading_t;

	typedef logic [30:0] exp_rom_t [ExpTableDepth];

	function automatic logic [63:0] isqrt64(logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] b;
		rem = v;
		res = 64'd0;
		b   = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + b) begin
				rem = rem - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// entry i = 2^(floor(i*65536/depth)/65536) in Q30, built from 2^(2^-j)
	function automatic exp_rom_t build_exp_rom();
		exp_rom_t    rom;
		logic [63:0] root [17];
		logic [63:0] f;
		logic [63:0] m;
		root[0] = 64'd1 << 31;
		for (int j = 1; j <= 16; j++)
			root[j] = isqrt64(root[j-1] << 30);
		for (int i = 0; i < ExpTableDepth; i++) begin
			f = (64'(i) << 16) / ExpTableDepth;
			m = 64'd1 << 30;
			for (int j = 1; j <= 16; j++)
				if (f[16-j])
					m = (m * root[j]) >> 30;
			rom[i] = m[30:0];
		end
		return rom;
	endfunction

	localparam exp_rom_t ExpRom = build_exp_rom();

endpackage

// ----- sv/gas_sensor_ppm_linearizer.sv -----
// ----------------------------------------------------------------------------
// gas_sensor_ppm_linearizer: chemiresistive sensor power-law ppm converter
// Averages ADC samples into readings and converts each reading to ppm.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive adc_sample/calibrate_window with push; a transfer
//   happens when push is high and full is low. One sample per cycle is
//   taken while the reading queue has room.
//   Result queue: a reading result is on ppm_q8/load_centivolts/status
//   while empty is low; pop transfers it.
//   Config: cfg_wr_en writes cfg_wdata to register cfg_addr (0 samples per
//   reading, 1 cal_ppm, 2 exponent_q12); write only while idle.
//   Each reading goes through a 20-step divider, two 16-step log2
//   squarings, then table and multiply stages; zero or full-scale voltage
//   and a missing calibration end it early. Non-final samples give no result.
//   A two-entry reading queue lets sampling continue while the linearizer
//   works; if the result is not popped the linearizer holds, the queue
//   fills, and full rises.
//   Reset clears the accumulator, queues and calibration reference and
//   loads the register defaults (20, 20, 8495).
// ----------------------------------------------------------------------------
module gas_sensor_ppm_linearizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [11:0] adc_sample,
	input  logic        calibrate_window,
	input  logic        pop,
	output logic        empty,
	output logic [31:0] ppm_q8,
	output logic [8:0]  load_centivolts,
	output logic [1:0]  status,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);

	logic [7:0]         spr_q;
	logic [15:0]        cal_ppm_q;
	logic [15:0]        exp_q;
	logic               take;
	logic               rd_valid;
	glpl_pkg::reading_t rd_in;
	glpl_pkg::reading_t rd_out;
	logic               fifo_empty;
	logic               rd_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_q     <= 8'd20;
			cal_ppm_q <= 16'd20;
			exp_q     <= 16'd8495;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				glpl_pkg::RegSamples: spr_q     <= cfg_wdata[7:0];
				glpl_pkg::RegCalPpm:  cal_ppm_q <= cfg_wdata;
				glpl_pkg::RegExp:     exp_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign take = push && !full;

	glpl_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.take                (take),
		.adc_sample          (adc_sample),
		.calibrate_window    (calibrate_window),
		.samples_per_reading (spr_q),
		.rd_valid            (rd_valid),
		.rd                  (rd_in)
	);

	glpl_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (rd_valid),
		.wr_data    (rd_in),
		.rd_en      (rd_take),
		.rd_data    (rd_out),
		.fifo_full  (full),
		.fifo_empty (fifo_empty)
	);

	glpl_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.rd_avail        (!fifo_empty),
		.rd              (rd_out),
		.rd_take         (rd_take),
		.cal_ppm         (cal_ppm_q),
		.exponent_q12    (exp_q),
		.pop             (pop),
		.empty           (empty),
		.ppm_q8          (ppm_q8),
		.load_centivolts (load_centivolts),
		.status          (status)
	);

endmodule

// ----- sv/glpl_front.sv -----
// ----------------------------------------------------------------------------
// glpl_front: sample accumulator
// Sums samples and emits one reading record per completed set.
// ----------------------------------------------------------------------------
module glpl_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                take,
	input  logic [glpl_pkg::AdcBits-1:0]        adc_sample,
	input  logic                                calibrate_window,
	input  logic [7:0]                          samples_per_reading,
	output logic                                rd_valid,
	output glpl_pkg::reading_t                  rd
);

	logic [glpl_pkg::SumW-1:0] sum_q;
	logic [7:0]                count_q;
	logic [glpl_pkg::SumW-1:0] sum_nx;
	logic [7:0]                count_nx;
	logic [7:0]                n_eff;
	logic                      complete;

	assign sum_nx   = sum_q + glpl_pkg::SumW'(adc_sample);
	assign count_nx = count_q + 8'd1;
	assign n_eff    = (samples_per_reading == 8'd0) ? 8'd1 : samples_per_reading;
	// count wraps to zero after 256 samples, which also completes a reading
	assign complete = (count_nx == 8'd0) || (count_nx >= n_eff);

	assign rd_valid = take && complete;
	assign rd.sum   = sum_nx;
	assign rd.count = (count_nx == 8'd0) ? 9'd256 : {1'b0, count_nx};
	assign rd.calib = calibrate_window;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (take) begin
			if (complete) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= sum_nx;
				count_q <= count_nx;
			end
		end
	end

endmodule

// ----- sv/glpl_fifo.sv -----
// ----------------------------------------------------------------------------
// glpl_fifo: reading queue
// Short register queue between accumulator and linearizer.
// ----------------------------------------------------------------------------
module glpl_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  glpl_pkg::reading_t wr_data,
	input  logic               rd_en,
	output glpl_pkg::reading_t rd_data,
	output logic               fifo_full,
	output logic               fifo_empty
);

	glpl_pkg::reading_t                mem_q [glpl_pkg::FifoDepth];
	logic [glpl_pkg::FifoPtrW-1:0]     wr_ptr_q;
	logic [glpl_pkg::FifoPtrW-1:0]     rd_ptr_q;
	logic [glpl_pkg::FifoPtrW:0]       fill_q;
	logic                              do_wr;
	logic                              do_rd;

	assign fifo_full  = (fill_q == (glpl_pkg::FifoPtrW+1)'(glpl_pkg::FifoDepth));
	assign fifo_empty = (fill_q == '0);
	assign do_wr      = wr_en && !fifo_full;
	assign do_rd      = rd_en && !fifo_empty;
	assign rd_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == glpl_pkg::FifoPtrW'(glpl_pkg::FifoDepth - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == glpl_pkg::FifoPtrW'(glpl_pkg::FifoDepth - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				fill_q <= fill_q + 1'b1;
			else if (do_rd && !do_wr)
				fill_q <= fill_q - 1'b1;
		end
	end

endmodule

// ----- sv/glpl_back.sv -----
// ----------------------------------------------------------------------------
// glpl_back: reading linearizer
// Divides, forms centivolts, takes log ratios and evaluates the power law.
// ----------------------------------------------------------------------------
module glpl_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_avail,
	input  glpl_pkg::reading_t rd,
	output logic               rd_take,
	input  logic [15:0]        cal_ppm,
	input  logic [15:0]        exponent_q12,
	input  logic               pop,
	output logic               empty,
	output logic [31:0]        ppm_q8,
	output logic [8:0]         load_centivolts,
	output logic [1:0]         status
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DIV   = 4'd1;
	localparam logic [3:0] S_CV    = 4'd2;
	localparam logic [3:0] S_CHK   = 4'd3;
	localparam logic [3:0] S_LOGA  = 4'd4;
	localparam logic [3:0] S_LOGB  = 4'd5;
	localparam logic [3:0] S_REF   = 4'd6;
	localparam logic [3:0] S_MULY  = 4'd7;
	localparam logic [3:0] S_ROM   = 4'd8;
	localparam logic [3:0] S_MULP  = 4'd9;
	localparam logic [3:0] S_SHIFT = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;

	localparam int DivCntW = $clog2(glpl_pkg::SumW + 1);
	localparam int CvProdW = glpl_pkg::AdcBits + 10;

	logic [3:0]                  state_q;
	logic [DivCntW-1:0]          div_cnt_q;
	logic [8:0]                  rem_q;
	logic [glpl_pkg::SumW-1:0]   quot_q;
	logic [8:0]                  divisor_q;
	logic                        calib_q;
	logic [8:0]                  cv_q;
	logic [30:0]                 log_m_q;
	logic [glpl_pkg::LogW-1:0]   log_res_q;
	logic [3:0]                  log_step_q;
	logic [glpl_pkg::LogW-1:0]   la_q;
	logic signed [glpl_pkg::LogW-1:0] ref_log_q;
	logic                        have_ref_q;
	logic signed [24:0]          diff_q;
	logic signed [41:0]          prod_q;
	logic signed [14:0]          ip_q;
	logic [30:0]                 entry_q;
	logic [46:0]                 p_q;
	logic [31:0]                 val_q;
	logic [1:0]                  st_q;
	logic                        res_valid_q;
	logic [31:0]                 ppm_q;
	logic [8:0]                  cv_out_q;
	logic [1:0]                  status_q;

	logic [9:0]                  trial;
	logic                        ge;
	logic [CvProdW-1:0]          cv_wide;
	logic [8:0]                  log_n;
	logic [3:0]                  log_k;
	logic [61:0]                 sq;
	logic [31:0]                 sq_t;
	logic signed [glpl_pkg::LogW-1:0] lr;
	logic signed [glpl_pkg::LogW-1:0] ref_eff;
	logic signed [42:0]          y;
	logic [15:0]                 fr;
	logic [28:0]                 idx_full;
	logic signed [15:0]          s;
	logic [78:0]                 shl;
	logic [5:0]                  nsh;
	logic [46:0]                 shr;
	logic                        out_free;

	assign out_free = !res_valid_q || pop;
	assign rd_take  = (state_q == S_IDLE) && rd_avail;

	assign trial = {rem_q, quot_q[glpl_pkg::SumW-1]};
	assign ge    = trial >= {1'b0, divisor_q};

	assign cv_wide = (CvProdW'(quot_q[glpl_pkg::AdcBits-1:0]) * CvProdW'(330)
		+ (CvProdW'(1) << (glpl_pkg::AdcBits - 1))) >> glpl_pkg::AdcBits;

	// log operand: 330-cv first, then cv
	assign log_n = (state_q == S_CHK) ? (glpl_pkg::CvFull - cv_q) : cv_q;
	always_comb begin
		log_k = 4'd0;
		for (int i = 1; i < 9; i++)
			if (log_n[i])
				log_k = 4'(i);
	end

	assign sq   = 62'(log_m_q) * 62'(log_m_q);
	assign sq_t = sq[61:30];

	assign lr      = $signed(la_q - log_res_q);
	assign ref_eff = calib_q ? lr : ref_log_q;

	assign y        = -(43'(prod_q));
	assign fr       = y[27:12];
	assign idx_full = 29'(fr) * 29'(glpl_pkg::ExpTableDepth);

	assign s   = 16'(ip_q) - 16'sd22;
	assign shl = 79'(p_q) << s[4:0];
	assign nsh = 6'(-s);
	assign shr = p_q >> nsh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ref_log_q   <= '0;
			have_ref_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop && res_valid_q && state_q != S_OUT)
				res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (rd_avail) begin
						rem_q     <= '0;
						quot_q    <= rd.sum;
						divisor_q <= rd.count[8:0];
						calib_q   <= rd.calib;
						div_cnt_q <= '0;
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q     <= ge ? 9'(trial - {1'b0, divisor_q}) : trial[8:0];
					quot_q    <= {quot_q[glpl_pkg::SumW-2:0], ge};
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DivCntW'(glpl_pkg::SumW - 1))
						state_q <= S_CV;
				end
				S_CV: begin
					cv_q    <= (cv_wide > CvProdW'(330)) ? glpl_pkg::CvFull : cv_wide[8:0];
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (cv_q == 9'd0) begin
						val_q   <= '0;
						st_q    <= glpl_pkg::StZero;
						state_q <= S_OUT;
					end else if (cv_q == glpl_pkg::CvFull) begin
						val_q   <= '1;
						st_q    <= glpl_pkg::StSat;
						state_q <= S_OUT;
					end else begin
						log_m_q    <= 31'(log_n) << (5'd30 - 5'(log_k));
						log_res_q  <= glpl_pkg::LogW'(log_k) << 16;
						log_step_q <= '0;
						state_q    <= S_LOGA;
					end
				end
				S_LOGA, S_LOGB: begin
					if (log_step_q == 4'd15 && state_q == S_LOGA) begin
						la_q       <= sq_t[31] ? (log_res_q | glpl_pkg::LogW'(1)) : log_res_q;
						log_m_q    <= 31'(log_n) << (5'd30 - 5'(log_k));
						log_res_q  <= glpl_pkg::LogW'(log_k) << 16;
						log_step_q <= '0;
						state_q    <= S_LOGB;
					end else begin
						// square the Q30 mantissa; overflow past 2 yields the next bit
						if (sq_t[31]) begin
							log_m_q <= sq_t[31:1];
							log_res_q[4'd15 - log_step_q] <= 1'b1;
						end else begin
							log_m_q <= sq_t[30:0];
						end
						log_step_q <= log_step_q + 1'b1;
						if (log_step_q == 4'd15)
							state_q <= S_REF;
					end
				end
				S_REF: begin
					if (calib_q) begin
						ref_log_q  <= lr;
						have_ref_q <= 1'b1;
					end
					if (!calib_q && !have_ref_q) begin
						val_q   <= '0;
						st_q    <= glpl_pkg::StNoCal;
						state_q <= S_OUT;
					end else begin
						diff_q  <= 25'(lr) - 25'(ref_eff);
						state_q <= S_MULY;
					end
				end
				S_MULY: begin
					prod_q  <= 42'(diff_q) * $signed({26'd0, exponent_q12});
					state_q <= S_ROM;
				end
				S_ROM: begin
					entry_q <= glpl_pkg::ExpRom[idx_full[16 +: glpl_pkg::ExpIdxW]];
					ip_q    <= 15'(y >>> 28);
					state_q <= S_MULP;
				end
				S_MULP: begin
					p_q     <= 47'(cal_ppm) * 47'(entry_q);
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					st_q <= glpl_pkg::StOk;
					if (p_q == '0) begin
						val_q <= '0;
					end else if (s >= 16'sd32) begin
						val_q <= '1;
						st_q  <= glpl_pkg::StSat;
					end else if (s >= 16'sd0) begin
						if (|shl[78:32]) begin
							val_q <= '1;
							st_q  <= glpl_pkg::StSat;
						end else begin
							val_q <= shl[31:0];
						end
					end else if (s <= -16'sd64) begin
						val_q <= '0;
					end else if (|shr[46:32]) begin
						val_q <= '1;
						st_q  <= glpl_pkg::StSat;
					end else begin
						val_q <= shr[31:0];
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						ppm_q       <= val_q;
						cv_out_q    <= cv_q;
						status_q    <= st_q;
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign empty           = !res_valid_q;
	assign ppm_q8          = ppm_q;
	assign load_centivolts = cv_out_q;
	assign status          = status_q;

	a_zero_cv: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && status_q == glpl_pkg::StZero |-> ppm_q == '0 && cv_out_q == '0)
		else $error("zero-voltage result carries nonzero data");
	a_cv_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> cv_out_q <= glpl_pkg::CvFull)
		else $error("centivolts out of range");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(res_valid_q) |-> $past(pop))
		else $error("result dropped without transfer");
	a_full_sat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && cv_out_q == glpl_pkg::CvFull |-> status_q == glpl_pkg::StSat)
		else $error("full voltage not saturated");

endmodule
